[sv/sdra_pkg.sv]
// Shared types, codes and helpers of the SPH density-rate accumulator.
package sdra_pkg;

   // Request type codes as they arrive on the input channel.
   localparam logic [1:0] REQ_LOAD = 2'd0;
   localparam logic [1:0] REQ_PAIR = 2'd1;
   localparam logic [1:0] REQ_READ = 2'd2;

   // Particle kinds.
   localparam logic [1:0] KIND_FLUID = 2'd0;
   localparam logic [1:0] KIND_WALL  = 2'd1;
   localparam logic [1:0] KIND_WEDGE = 2'd2;

   localparam int IDX_W   = 12;
   localparam int MUL_A_W = 50;
   localparam int MUL_B_W = 33;

   typedef enum logic [1:0] {
      OP_LOAD,
      OP_PAIR,
      OP_READ
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [IDX_W-1:0]   idx;
      logic [IDX_W-1:0]   other;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic [30:0]        mass;
      logic [1:0]         kind;
      logic signed [31:0] grad_x;
      logic signed [31:0] grad_y;
   } entry_type;

   typedef struct packed {
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] omega;
      logic signed [31:0] center_x;
      logic signed [31:0] center_y;
   } wedge_type;

   typedef struct packed {
      logic                       start;
      logic signed [MUL_A_W-1:0]  a;
      logic signed [MUL_B_W-1:0]  b;
   } mul_req_type;

   typedef struct packed {
      logic               done;
      logic signed [47:0] value;
      logic               sat;
   } mul_rsp_type;

   typedef struct packed {
      logic signed [47:0] value;
      logic               sat;
   } sat_type;

   localparam logic signed [50:0] LIM_POS = 51'sd140737488355327;
   localparam logic signed [50:0] LIM_NEG = -51'sd140737488355328;

   // Clamp to the signed 48-bit range, flag when clamped.
   function automatic sat_type sat48(input logic signed [50:0] v);
      sat_type r;
      r.sat = 1'b1;
      if (v > LIM_POS) begin
         r.value = 48'sh7FFF_FFFF_FFFF;
      end else if (v < LIM_NEG) begin
         r.value = 48'sh8000_0000_0000;
      end else begin
         r.sat   = 1'b0;
         r.value = v[47:0];
      end
      return r;
   endfunction

endpackage

[sv/sdra_front.sv]
// Front end: qualifies and classifies requests before they enter the queue.
module sdra_front #(
   parameter int NUM_PARTICLES = 4096
) (
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [1:0]                req_type,
   input  logic [11:0]               req_index,
   input  logic [11:0]               req_other_index,
   input  logic signed [31:0]        req_vel_x,
   input  logic signed [31:0]        req_vel_y,
   input  logic signed [31:0]        req_pos_x,
   input  logic signed [31:0]        req_pos_y,
   input  logic [30:0]               req_mass,
   input  logic [1:0]                req_kind,
   input  logic signed [31:0]        req_grad_x,
   input  logic signed [31:0]        req_grad_y,
   input  logic                      queue_full,
   output logic                      push,
   output sdra_pkg::entry_type       entry
);
   import sdra_pkg::*;

   logic in_range_i;
   logic in_range_j;
   logic keep;

   assign in_range_i = (32'(req_index) < NUM_PARTICLES);
   assign in_range_j = (32'(req_other_index) < NUM_PARTICLES);

   always_comb begin
      entry.idx    = req_index;
      entry.other  = req_other_index;
      entry.vel_x  = req_vel_x;
      entry.vel_y  = req_vel_y;
      entry.pos_x  = req_pos_x;
      entry.pos_y  = req_pos_y;
      entry.mass   = req_mass;
      entry.kind   = req_kind;
      entry.grad_x = req_grad_x;
      entry.grad_y = req_grad_y;
      entry.op     = OP_LOAD;
      keep         = 1'b0;
      unique case (req_type)
         REQ_LOAD: begin
            keep = in_range_i;
         end
         REQ_PAIR: begin
            entry.op = OP_PAIR;
            keep     = in_range_i & in_range_j;
         end
         REQ_READ: begin
            entry.op = OP_READ;
            keep     = in_range_i;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   // dropped items are still taken off the channel
   assign req_stall = queue_full;
   assign push      = req_valid & ~queue_full & keep;

endmodule

[sv/sdra_fifo.sv]
// Two-entry queue between the front end and the execution back end.
module sdra_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  sdra_pkg::entry_type   push_data,
   input  logic                  pop,
   output sdra_pkg::entry_type   head,
   output logic                  head_valid,
   output logic                  full
);
   import sdra_pkg::*;

   entry_type  slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign head       = slot_ff[rd_ptr_ff];
   assign head_valid = (count_ff != 2'd0);
   assign full       = (count_ff == 2'd2);

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[sv/sdra_mul.sv]
// Shared Q16.16 multiplier: 16-bit digit per cycle, floored and clamped to 48 bits.
module sdra_mul (
   input  logic                  clock,
   input  logic                  reset,
   input  sdra_pkg::mul_req_type req,
   output sdra_pkg::mul_rsp_type rsp
);
   import sdra_pkg::*;

   localparam int PROD_W = MUL_A_W + 32;
   localparam logic [PROD_W-15:0] HALF = (PROD_W-14)'(1) << 47;

   logic [MUL_A_W-1:0]  mag_a_ff;
   logic [31:0]         mag_b_ff;
   logic                neg_ff;
   logic [PROD_W-1:0]   acc_ff;
   logic                busy_ff;
   logic                digit_ff;
   logic                fin_ff;
   mul_rsp_type         rsp_ff;

   logic [15:0]               digit;
   logic [MUL_A_W+15:0]       pp;
   logic [PROD_W-1:0]         acc_in;
   logic [PROD_W-15:0]        mag_r;
   logic                      sat_r;
   logic signed [47:0]        value_r;

   always_comb begin
      digit  = digit_ff ? mag_b_ff[31:16] : mag_b_ff[15:0];
      pp     = mag_a_ff * digit;
      acc_in = acc_ff + (PROD_W'(pp) << (digit_ff ? 16 : 0));
      // floor toward minus infinity: round the magnitude up when negative
      mag_r  = (PROD_W-14)'(acc_ff[PROD_W-1:16]) + (PROD_W-14)'(neg_ff & (|acc_ff[15:0]));
      sat_r  = neg_ff ? (mag_r > HALF) : (mag_r >= HALF);
      if (sat_r) begin
         value_r = neg_ff ? 48'sh8000_0000_0000 : 48'sh7FFF_FFFF_FFFF;
      end else begin
         value_r = neg_ff ? -$signed(mag_r[47:0]) : $signed(mag_r[47:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         fin_ff      <= 1'b0;
         digit_ff    <= 1'b0;
         rsp_ff.done <= 1'b0;
      end else begin
         rsp_ff.done <= 1'b0;
         if (req.start) begin
            mag_a_ff <= req.a[MUL_A_W-1] ? MUL_A_W'(-req.a) : MUL_A_W'(req.a);
            mag_b_ff <= req.b[MUL_B_W-1] ? 32'(-req.b) : 32'(req.b);
            neg_ff   <= req.a[MUL_A_W-1] ^ req.b[MUL_B_W-1];
            acc_ff   <= '0;
            busy_ff  <= 1'b1;
            digit_ff <= 1'b0;
         end else if (busy_ff) begin
            acc_ff   <= acc_in;
            digit_ff <= ~digit_ff;
            if (digit_ff) begin
               busy_ff <= 1'b0;
               fin_ff  <= 1'b1;
            end
         end else if (fin_ff) begin
            fin_ff       <= 1'b0;
            rsp_ff.done  <= 1'b1;
            rsp_ff.value <= value_r;
            rsp_ff.sat   <= sat_r;
         end
      end
   end

   assign rsp = rsp_ff;

endmodule

[sv/sdra_back.sv]
// Back end: particle tables, accumulator memory, pair sequencer, result register.
module sdra_back #(
   parameter int NUM_PARTICLES = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  sdra_pkg::entry_type   head,
   input  logic                  head_valid,
   output logic                  pop,
   input  sdra_pkg::wedge_type   wedge,
   output sdra_pkg::mul_req_type mul_req,
   input  sdra_pkg::mul_rsp_type mul_rsp,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [11:0]           rsp_read_index,
   output logic signed [47:0]    rsp_density_rate,
   output logic                  rsp_saturated
);
   import sdra_pkg::*;

   localparam int AW = (NUM_PARTICLES > 1) ? $clog2(NUM_PARTICLES) : 1;

   typedef enum logic [3:0] {
      S_IDLE, S_READ, S_FETCH, S_W1, S_W2, S_TX, S_TY, S_A1, S_RMW1, S_A2, S_RMW2
   } state_type;

   // particle tables
   logic [31:0] vel_x_mem [NUM_PARTICLES];
   logic [31:0] vel_y_mem [NUM_PARTICLES];
   logic [31:0] pos_x_mem [NUM_PARTICLES];
   logic [31:0] pos_y_mem [NUM_PARTICLES];
   logic [30:0] mass_mem  [NUM_PARTICLES];
   logic [1:0]  kind_mem  [NUM_PARTICLES];
   logic [47:0] rate_mem  [NUM_PARTICLES];
   logic        sat_mem   [NUM_PARTICLES];

   logic signed [31:0] vx_a_ff, vx_b_ff, vy_a_ff, vy_b_ff, px_b_ff, py_b_ff;
   logic [30:0]        mass_a_ff, mass_b_ff;
   logic [1:0]         kind_b_ff;
   logic signed [47:0] rate_rd_ff;
   logic               sat_rd_ff;

   state_type          state_ff;
   logic [AW-1:0]      idx_a_ff, idx_b_ff;
   logic [11:0]        idx12_ff;
   logic signed [31:0] gx_ff, gy_ff;
   logic signed [MUL_A_W-1:0] dvx_ff, dvy_ff;
   logic signed [47:0] tx_ff, temp_ff, add_ff;
   logic               tsat_ff, asat_ff;
   mul_req_type        mul_req_ff;
   logic               rsp_valid_ff;
   logic [11:0]        rsp_index_ff;
   logic signed [47:0] rsp_rate_ff;
   logic               rsp_sat_ff;

   logic [AW-1:0]      head_a, head_b;
   logic               wr_load, rd_pair;
   logic               rate_re, rate_we;
   logic [AW-1:0]      rate_raddr, rate_waddr;
   logic [47:0]        rate_wdata;
   logic               sat_wdata;
   logic               out_free;
   logic signed [MUL_A_W-1:0] dv_fx, dv_fy, dv_wx, dv_wy, d_y, d_x;
   sat_type            temp_s, rmw_s;

   assign head_a   = AW'(head.idx);
   assign head_b   = AW'(head.other);
   assign out_free = ~rsp_valid_ff | ~rsp_stall;

   always_comb begin
      dv_fx  = MUL_A_W'(vx_a_ff) - MUL_A_W'(vx_b_ff);
      dv_fy  = MUL_A_W'(vy_a_ff) - MUL_A_W'(vy_b_ff);
      d_y    = MUL_A_W'(py_b_ff) - MUL_A_W'(wedge.center_y);
      d_x    = MUL_A_W'(px_b_ff) - MUL_A_W'(wedge.center_x);
      // v_i - (u - w*dy), v_i - (u + w*dx)
      dv_wx  = MUL_A_W'(vx_a_ff) - MUL_A_W'(wedge.vel_x) + MUL_A_W'(mul_rsp.value);
      dv_wy  = MUL_A_W'(vy_a_ff) - MUL_A_W'(wedge.vel_y) - MUL_A_W'(mul_rsp.value);
      temp_s = sat48(51'(tx_ff) + 51'(mul_rsp.value));
      rmw_s  = sat48(51'(rate_rd_ff) + 51'(add_ff));
   end

   // memory control
   always_comb begin
      pop        = 1'b0;
      wr_load    = 1'b0;
      rd_pair    = 1'b0;
      rate_re    = 1'b0;
      rate_we    = 1'b0;
      rate_raddr = idx_a_ff;
      rate_waddr = idx_a_ff;
      rate_wdata = rmw_s.value;
      sat_wdata  = sat_rd_ff | asat_ff | rmw_s.sat;
      unique case (state_ff)
         S_IDLE: begin
            if (head_valid) begin
               pop = 1'b1;
               unique case (head.op)
                  OP_LOAD: begin
                     wr_load    = 1'b1;
                     rate_we    = 1'b1;
                     rate_waddr = head_a;
                     rate_wdata = '0;
                     sat_wdata  = 1'b0;
                  end
                  OP_READ: begin
                     rate_re    = 1'b1;
                     rate_raddr = head_a;
                  end
                  OP_PAIR: rd_pair = 1'b1;
                  default: ;
               endcase
            end
         end
         S_A1: rate_re = mul_rsp.done;
         S_RMW1: rate_we = 1'b1;
         S_A2: begin
            rate_re    = mul_rsp.done;
            rate_raddr = idx_b_ff;
         end
         S_RMW2: begin
            rate_we    = 1'b1;
            rate_waddr = idx_b_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_load) begin
         vel_x_mem[head_a] <= head.vel_x;
         vel_y_mem[head_a] <= head.vel_y;
         pos_x_mem[head_a] <= head.pos_x;
         pos_y_mem[head_a] <= head.pos_y;
         mass_mem[head_a]  <= head.mass;
         kind_mem[head_a]  <= head.kind;
      end
      if (rd_pair) begin
         vx_a_ff   <= vel_x_mem[head_a];
         vy_a_ff   <= vel_y_mem[head_a];
         mass_a_ff <= mass_mem[head_a];
         vx_b_ff   <= vel_x_mem[head_b];
         vy_b_ff   <= vel_y_mem[head_b];
         px_b_ff   <= pos_x_mem[head_b];
         py_b_ff   <= pos_y_mem[head_b];
         mass_b_ff <= mass_mem[head_b];
         kind_b_ff <= kind_mem[head_b];
      end
   end

   always_ff @(posedge clock) begin
      if (rate_we) begin
         rate_mem[rate_waddr] <= rate_wdata;
         sat_mem[rate_waddr]  <= sat_wdata;
      end
      if (rate_re) begin
         rate_rd_ff <= rate_mem[rate_raddr];
         sat_rd_ff  <= sat_mem[rate_raddr];
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         mul_req_ff.start <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         mul_req_ff.start <= 1'b0;
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (head_valid) begin
                  idx_a_ff <= head_a;
                  idx_b_ff <= head_b;
                  idx12_ff <= head.idx;
                  gx_ff    <= head.grad_x;
                  gy_ff    <= head.grad_y;
                  tsat_ff  <= 1'b0;
                  unique case (head.op)
                     OP_READ: state_ff <= S_READ;
                     OP_PAIR: state_ff <= S_FETCH;
                     default: state_ff <= S_IDLE;
                  endcase
               end
            end
            S_READ: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_index_ff <= idx12_ff;
                  rsp_rate_ff  <= rate_rd_ff;
                  rsp_sat_ff   <= sat_rd_ff;
                  state_ff     <= S_IDLE;
               end
            end
            S_FETCH: begin
               mul_req_ff.start <= 1'b1;
               mul_req_ff.b     <= MUL_B_W'(gx_ff);
               unique case (kind_b_ff)
                  KIND_FLUID: begin
                     mul_req_ff.a <= dv_fx;
                     dvy_ff       <= dv_fy;
                     state_ff     <= S_TX;
                  end
                  KIND_WALL: begin
                     mul_req_ff.a <= MUL_A_W'(vx_a_ff);
                     dvy_ff       <= MUL_A_W'(vy_a_ff);
                     state_ff     <= S_TX;
                  end
                  KIND_WEDGE: begin
                     mul_req_ff.a <= d_y;
                     mul_req_ff.b <= MUL_B_W'(wedge.omega);
                     state_ff     <= S_W1;
                  end
                  default: begin
                     // other kinds contribute nothing
                     temp_ff      <= '0;
                     mul_req_ff.a <= '0;
                     mul_req_ff.b <= MUL_B_W'(mass_b_ff);
                     state_ff     <= S_A1;
                  end
               endcase
            end
            S_W1: begin
               if (mul_rsp.done) begin
                  dvx_ff           <= dv_wx;
                  mul_req_ff.start <= 1'b1;
                  mul_req_ff.a     <= d_x;
                  mul_req_ff.b     <= MUL_B_W'(wedge.omega);
                  state_ff         <= S_W2;
               end
            end
            S_W2: begin
               if (mul_rsp.done) begin
                  dvy_ff           <= dv_wy;
                  mul_req_ff.start <= 1'b1;
                  mul_req_ff.a     <= dvx_ff;
                  mul_req_ff.b     <= MUL_B_W'(gx_ff);
                  state_ff         <= S_TX;
               end
            end
            S_TX: begin
               if (mul_rsp.done) begin
                  tx_ff            <= mul_rsp.value;
                  tsat_ff          <= mul_rsp.sat;
                  mul_req_ff.start <= 1'b1;
                  mul_req_ff.a     <= dvy_ff;
                  mul_req_ff.b     <= MUL_B_W'(gy_ff);
                  state_ff         <= S_TY;
               end
            end
            S_TY: begin
               if (mul_rsp.done) begin
                  temp_ff          <= temp_s.value;
                  tsat_ff          <= tsat_ff | mul_rsp.sat | temp_s.sat;
                  mul_req_ff.start <= 1'b1;
                  mul_req_ff.a     <= MUL_A_W'(temp_s.value);
                  mul_req_ff.b     <= MUL_B_W'(mass_b_ff);
                  state_ff         <= S_A1;
               end
            end
            S_A1: begin
               if (mul_rsp.done) begin
                  add_ff   <= mul_rsp.value;
                  asat_ff  <= tsat_ff | mul_rsp.sat;
                  state_ff <= S_RMW1;
               end
            end
            S_RMW1: begin
               mul_req_ff.start <= 1'b1;
               mul_req_ff.a     <= MUL_A_W'(temp_ff);
               mul_req_ff.b     <= MUL_B_W'(mass_a_ff);
               state_ff         <= S_A2;
            end
            S_A2: begin
               if (mul_rsp.done) begin
                  add_ff   <= mul_rsp.value;
                  asat_ff  <= tsat_ff | mul_rsp.sat;
                  state_ff <= S_RMW2;
               end
            end
            S_RMW2: state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign mul_req          = mul_req_ff;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_index   = rsp_index_ff;
   assign rsp_density_rate = rsp_rate_ff;
   assign rsp_saturated    = rsp_sat_ff;

endmodule

[sv/sph_density_rate_accumulator_core.sv]
// SPH continuity-equation density-rate accumulator, top level.
// Keeps a table of NUM_PARTICLES particles (velocity, position, mass, kind) and
// one signed Q32.16 density-rate accumulator with a sticky saturation flag per
// particle. Request types: load (writes a particle, clears its accumulator and
// flag), pair (adds m_j*(dv.grad) to particle i, then m_i*(dv.grad) to
// particle j; the partner velocity is the fluid velocity, zero for a fixed wall,
// or the rigid-body velocity set by the wedge registers; other kinds add zero),
// and read (returns one accumulator and its flag). Requests with an index at or
// beyond NUM_PARTICLES, and type 3, are taken and dropped. A front end screens
// requests into a two-entry queue; the back end runs them one at a time. Every
// product comes from one shared 50x16 multiplier, and a wedge partner needs
// extra products; a read also waits until the result register is free. Wedge
// registers may only be written while no request is in flight. Table contents
// are undefined until a particle is loaded; there is no clearing pass.
module sph_density_rate_accumulator_core #(
   parameter int NUM_PARTICLES = 4096
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_type,
   input  logic [11:0]        req_index,
   input  logic [11:0]        req_other_index,
   input  logic signed [31:0] req_vel_x,
   input  logic signed [31:0] req_vel_y,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic [30:0]        req_mass,
   input  logic [1:0]         req_kind,
   input  logic signed [31:0] req_grad_x,
   input  logic signed [31:0] req_grad_y,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [11:0]        rsp_read_index,
   output logic signed [47:0] rsp_density_rate,
   output logic               rsp_saturated
);
   import sdra_pkg::*;

   // register map
   localparam logic [2:0] CSR_WEDGE_VEL_X    = 3'd0;
   localparam logic [2:0] CSR_WEDGE_VEL_Y    = 3'd1;
   localparam logic [2:0] CSR_WEDGE_OMEGA    = 3'd2;
   localparam logic [2:0] CSR_WEDGE_CENTER_X = 3'd3;
   localparam logic [2:0] CSR_WEDGE_CENTER_Y = 3'd4;

   wedge_type   wedge_ff;
   entry_type   push_entry;
   entry_type   head;
   logic        push, pop, head_valid, queue_full;
   mul_req_type mul_req;
   mul_rsp_type mul_rsp;

   // wedge rigid-body registers; writes beyond the map are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         wedge_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_WEDGE_VEL_X:    wedge_ff.vel_x    <= csr_data;
            CSR_WEDGE_VEL_Y:    wedge_ff.vel_y    <= csr_data;
            CSR_WEDGE_OMEGA:    wedge_ff.omega    <= csr_data;
            CSR_WEDGE_CENTER_X: wedge_ff.center_x <= csr_data;
            CSR_WEDGE_CENTER_Y: wedge_ff.center_y <= csr_data;
            default: ;
         endcase
      end
   end

   sdra_front #(
      .NUM_PARTICLES (NUM_PARTICLES)
   ) u_front (
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_index       (req_index),
      .req_other_index (req_other_index),
      .req_vel_x       (req_vel_x),
      .req_vel_y       (req_vel_y),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_mass        (req_mass),
      .req_kind        (req_kind),
      .req_grad_x      (req_grad_x),
      .req_grad_y      (req_grad_y),
      .queue_full      (queue_full),
      .push            (push),
      .entry           (push_entry)
   );

   sdra_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_entry),
      .pop        (pop),
      .head       (head),
      .head_valid (head_valid),
      .full       (queue_full)
   );

   sdra_mul u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mul_req),
      .rsp   (mul_rsp)
   );

   sdra_back #(
      .NUM_PARTICLES (NUM_PARTICLES)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .head_valid       (head_valid),
      .pop              (pop),
      .wedge            (wedge_ff),
      .mul_req          (mul_req),
      .mul_rsp          (mul_rsp),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_read_index   (rsp_read_index),
      .rsp_density_rate (rsp_density_rate),
      .rsp_saturated    (rsp_saturated)
   );

endmodule

[tb/tb_sph_density_rate_accumulator_core.sv]
// Self-checking testbench for the SPH density-rate accumulator core.
`timescale 1ns / 100ps

module tb_sph_density_rate_accumulator_core;
   import sdra_pkg::*;

   // Request code and particle kind that the package does not name.
   localparam logic [1:0] REQ_NONE   = 2'd3;
   localparam logic [1:0] KIND_OTHER = 2'd3;

   // Wedge register indexes.
   localparam logic [2:0] REG_VEL_X    = 3'd0;
   localparam logic [2:0] REG_VEL_Y    = 3'd1;
   localparam logic [2:0] REG_OMEGA    = 3'd2;
   localparam logic [2:0] REG_CENTER_X = 3'd3;
   localparam logic [2:0] REG_CENTER_Y = 3'd4;

   localparam int NPART      = 4096;
   localparam int POOL_SIZE  = 24;
   localparam int DRAIN_WAIT = 150;   // room for three queued wedge pairs to finish
   localparam int IDLE_LIMIT = 6000;
   localparam int NUM_PHASES = 6;
   localparam int PHASE_ITEMS = 255;

   typedef struct {
      logic [1:0]         code;
      logic [11:0]        idx;
      logic [11:0]        other;
      logic signed [31:0] vel_x, vel_y, pos_x, pos_y;
      logic [30:0]        mass;
      logic [1:0]         kind;
      logic signed [31:0] grad_x, grad_y;
   } request_type;

   typedef struct {
      logic [11:0]        idx;
      logic signed [47:0] rate;
      logic               sat;
   } readout_type;

   // Keeps its own copy of the particle table and predicts every read.
   class density_scoreboard;
      logic signed [31:0] vx[NPART], vy[NPART], px[NPART], py[NPART];
      logic [30:0]        m[NPART];
      logic [1:0]         k[NPART];
      logic signed [47:0] rate[NPART];
      logic               sat[NPART];
      logic signed [31:0] wreg[5];
      readout_type        pending[$];
      int errors, reads_seen, loads, pairs, ignored;

      function new();
         foreach (wreg[r]) wreg[r] = 0;
         errors = 0; reads_seen = 0; loads = 0; pairs = 0; ignored = 0;
      endfunction

      // Exact product floored to Q.16.
      function logic signed [127:0] qmul(logic signed [127:0] a, logic signed [127:0] b);
         return (a * b) >>> 16;
      endfunction

      function logic signed [47:0] clamp48(logic signed [127:0] v, inout logic s);
         if (v > 128'sh7FFF_FFFF_FFFF) begin
            s = 1'b1;
            return 48'sh7FFF_FFFF_FFFF;
         end
         if (v < -128'sh8000_0000_0000) begin
            s = 1'b1;
            return 48'sh8000_0000_0000;
         end
         return v[47:0];
      endfunction

      function void add_rate(int n, logic [30:0] mass, logic signed [47:0] temp, logic tsat);
         logic                s;
         logic signed [127:0] addend;
         s = tsat;
         addend = clamp48(qmul($signed({1'b0, mass}), temp), s);
         rate[n] = clamp48(rate[n] + addend, s);
         if (s) sat[n] = 1'b1;
      endfunction

      function void note_request(request_type rq);
         logic signed [127:0] dvx, dvy, rx, ry;
         logic signed [47:0]  temp, tx, ty;
         logic                ts;
         int i, j;
         i = rq.idx; j = rq.other;
         dvx = 0; dvy = 0; temp = 0; ts = 1'b0;
         case (rq.code)
            REQ_LOAD: begin
               vx[i] = rq.vel_x; vy[i] = rq.vel_y; px[i] = rq.pos_x; py[i] = rq.pos_y;
               m[i] = rq.mass; k[i] = rq.kind; rate[i] = 0; sat[i] = 1'b0;
               loads++;
            end
            REQ_PAIR: begin
               case (k[j])
                  KIND_FLUID: begin
                     dvx = vx[i]; dvx = dvx - vx[j];
                     dvy = vy[i]; dvy = dvy - vy[j];
                  end
                  KIND_WALL: begin
                     dvx = vx[i]; dvy = vy[i];
                  end
                  KIND_WEDGE: begin
                     // rigid-body velocity at the partner's position
                     rx = py[j]; rx = wreg[REG_VEL_X] - qmul(wreg[REG_OMEGA], rx - wreg[REG_CENTER_Y]);
                     ry = px[j]; ry = wreg[REG_VEL_Y] + qmul(wreg[REG_OMEGA], ry - wreg[REG_CENTER_X]);
                     dvx = vx[i]; dvx = dvx - rx;
                     dvy = vy[i]; dvy = dvy - ry;
                  end
                  default: ;
               endcase
               if (k[j] != KIND_OTHER) begin
                  tx = clamp48(qmul(dvx, rq.grad_x), ts);
                  ty = clamp48(qmul(dvy, rq.grad_y), ts);
                  temp = clamp48(128'(tx) + 128'(ty), ts);
               end
               add_rate(i, m[j], temp, ts);
               add_rate(j, m[i], temp, ts);
               pairs++;
            end
            REQ_READ: pending.push_back('{idx: rq.idx, rate: rate[i], sat: sat[i]});
            default: ignored++;
         endcase
      endfunction

      task report(string what);
         $display("mismatch @%0t: %s", $time, what);
         errors++;
      endtask

      task check_readout(readout_type got);
         readout_type want;
         reads_seen++;
         if (pending.size() == 0) begin
            report($sformatf("unexpected read result for particle %0d", got.idx));
            return;
         end
         want = pending.pop_front();
         if (got.idx !== want.idx)
            report($sformatf("read_index %0d, want %0d", got.idx, want.idx));
         if (got.rate !== want.rate)
            report($sformatf("density_rate of %0d is %0d, want %0d", want.idx, got.rate, want.rate));
         if (got.sat !== want.sat)
            report($sformatf("saturated of %0d is %0b, want %0b", want.idx, got.sat, want.sat));
      endtask
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_write = 1'b0;
   logic [2:0]         csr_index = '0;
   logic [31:0]        csr_data = '0;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_type = '0;
   logic [11:0]        req_index = '0, req_other_index = '0;
   logic signed [31:0] req_vel_x = '0, req_vel_y = '0, req_pos_x = '0, req_pos_y = '0;
   logic [30:0]        req_mass = '0;
   logic [1:0]         req_kind = '0;
   logic signed [31:0] req_grad_x = '0, req_grad_y = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b1;
   logic [11:0]        rsp_read_index;
   logic signed [47:0] rsp_density_rate;
   logic               rsp_saturated;

   density_scoreboard board = new();
   logic [11:0] pool[POOL_SIZE];
   int  send_max_gap = 16, recv_max_wait = 16;
   int  hold_request = 0;    // receiver stall stretch asked for by the stimulus
   int  idle_cycles = 0;

   always #4 clock = ~clock;

   sph_density_rate_accumulator_core i_dut (.*);

   // Watchdog: counts cycles in which neither channel moves an item.
   always @(negedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
         $display("FAILED: results differ");
         $finish;
      end
   end

   // Result side: random stall before each item, checked at the accepting edge.
   initial begin : result_sink
      readout_type got;
      int wait_cycles;
      @(negedge reset);
      forever begin
         wait_cycles = (hold_request > 0) ? hold_request : $urandom_range(recv_max_wait, 0);
         hold_request = 0;
         if (wait_cycles > 0) begin
            // stall from this very edge so no item slips through unchecked
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         forever begin
            @(negedge clock);
            if (rsp_valid) break;
         end
         got = '{idx: rsp_read_index, rate: rsp_density_rate, sat: rsp_saturated};
         @(posedge clock);
         board.check_readout(got);
      end
   end

   // Offer one item after a random gap; valid stays up across back-to-back items.
   task automatic send_item(request_type rq);
      int gap;
      gap = $urandom_range(send_max_gap, 0);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= rq.code; req_index <= rq.idx; req_other_index <= rq.other;
      req_vel_x <= rq.vel_x; req_vel_y <= rq.vel_y;
      req_pos_x <= rq.pos_x; req_pos_y <= rq.pos_y;
      req_mass <= rq.mass; req_kind <= rq.kind;
      req_grad_x <= rq.grad_x; req_grad_y <= rq.grad_y;
      forever begin
         @(negedge clock);
         if (!req_stall) break;
      end
      @(posedge clock);
      board.note_request(rq);
   endtask

   // Mostly moderate values so sums stay in range; one in eight spans all 32 bits.
   function automatic logic signed [31:0] pick_value();
      if ($urandom_range(7, 0) == 0) return $urandom();
      return $signed($urandom_range(32'h0020_0000, 0)) - 32'sh0010_0000;
   endfunction

   function automatic request_type blank(logic [1:0] code, int i, int j);
      request_type rq;
      rq.code = code; rq.idx = i; rq.other = j;
      rq.vel_x = 0; rq.vel_y = 0; rq.pos_x = 0; rq.pos_y = 0;
      rq.mass = 0; rq.kind = KIND_FLUID; rq.grad_x = 0; rq.grad_y = 0;
      return rq;
   endfunction

   function automatic request_type load_of(int i, logic [1:0] kind);
      request_type rq;
      rq = blank(REQ_LOAD, i, $urandom_range(NPART - 1, 0));
      rq.vel_x = pick_value(); rq.vel_y = pick_value();
      rq.pos_x = pick_value(); rq.pos_y = pick_value();
      rq.mass = ($urandom_range(7, 0) == 0) ? 31'($urandom()) : 31'($urandom_range(32'h0004_0000, 0));
      rq.kind = kind;
      rq.grad_x = $urandom(); rq.grad_y = $urandom();
      return rq;
   endfunction

   function automatic request_type pair_of(int i, int j);
      request_type rq;
      rq = blank(REQ_PAIR, i, j);
      rq.grad_x = pick_value(); rq.grad_y = pick_value();
      rq.vel_x = $urandom(); rq.pos_y = $urandom();   // ignored on a pair
      return rq;
   endfunction

   function automatic request_type random_item();
      int dice;
      dice = $urandom_range(99, 0);
      if (dice < 20) return load_of(pool[$urandom_range(POOL_SIZE - 1, 0)], 2'($urandom()));
      if (dice < 65) return pair_of(pool[$urandom_range(POOL_SIZE - 1, 0)],
                                    pool[$urandom_range(POOL_SIZE - 1, 0)]);
      if (dice < 96) return blank(REQ_READ, pool[$urandom_range(POOL_SIZE - 1, 0)], $urandom());
      return blank(REQ_NONE, $urandom_range(NPART - 1, 0), $urandom_range(NPART - 1, 0));
   endfunction

   // All five wedge registers in one burst; write enable stays high throughout.
   task automatic write_wedge(logic [31:0] vals[5]);
      for (int r = 0; r < 5; r++) begin
         @(posedge clock);
         csr_write <= 1'b1; csr_index <= 3'(r); csr_data <= vals[r];
         board.wreg[r] = vals[r];
      end
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   initial begin : stimulus
      request_type rq;
      logic [31:0] vals[5];
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      pool[0] = 0; pool[1] = NPART - 1;
      for (int p = 2; p < POOL_SIZE; p++) pool[p] = $urandom_range(NPART - 1, 0);

      // Directed: extremes, each partner kind, same index twice, saturation.
      vals = '{32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, 32'h0002_0000, 32'hFFFE_0000};
      write_wedge(vals);
      rq = load_of(0, KIND_FLUID);
      rq.vel_x = 32'sh7FFF_FFFF; rq.vel_y = 32'sh8000_0000; rq.mass = 31'h7FFF_FFFF;
      send_item(rq);
      rq = load_of(NPART - 1, KIND_WALL);
      rq.vel_x = 32'sh8000_0000; rq.vel_y = 32'sh7FFF_FFFF; rq.mass = 31'h7FFF_FFFF;
      send_item(rq);
      for (int p = 2; p < POOL_SIZE; p++) send_item(load_of(pool[p], 2'(p)));
      rq = pair_of(0, NPART - 1);
      rq.grad_x = 32'sh7FFF_FFFF; rq.grad_y = 32'sh8000_0000;
      send_item(rq);                                       // saturates both sides
      send_item(pair_of(pool[2], pool[3]));                // other partner
      send_item(pair_of(pool[3], pool[4]));                // fluid partner
      send_item(pair_of(pool[4], pool[5]));                // wall partner
      send_item(pair_of(pool[6], pool[6]));                // same index twice
      send_item(blank(REQ_NONE, 5, 6));
      send_item(blank(REQ_READ, 0, 0));
      send_item(blank(REQ_READ, NPART - 1, 0));
      for (int p = 2; p < 7; p++) send_item(blank(REQ_READ, pool[p], 0));
      drain();

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         case (ph)
            0: vals = '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0};
            1: vals = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
            2: vals = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
            3: foreach (vals[r]) vals[r] = $urandom();
            default: foreach (vals[r]) vals[r] = pick_value();
         endcase
         write_wedge(vals);
         // No idling on one phase; a long receiver hold-off on another.
         send_max_gap  = (ph == 2) ? 0 : 16;
         recv_max_wait = (ph == 2) ? 0 : 16;
         if (ph == 4) hold_request = 400;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            rq = random_item();
            if (ph == 4 && n < 40 && rq.code != REQ_READ) rq = blank(REQ_READ, pool[n % POOL_SIZE], 0);
            send_item(rq);
         end
         drain();
      end

      $display("covered %0d loads, %0d pairs, %0d reads checked, %0d ignored requests",
               board.loads, board.pairs, board.reads_seen, board.ignored);
      $display("wedge registers swept through zero, both extremes and random settings");
      if (board.errors == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
